@@ hdl/sagr_pkg.sv @@
package sagr_pkg;

  localparam int unsigned SUM_FIELD_W       = 32;
  localparam int unsigned COUNT_W           = 16;
  localparam int unsigned LEVEL_W           = 8;
  localparam int unsigned NUM_CHAN          = 3;
  localparam int unsigned DEFAULT_SUM_WIDTH = 32;
  localparam int unsigned DEFAULT_FRAC_BITS = 16;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd254;

  // partial root and its square
  typedef struct packed {
    logic [LEVEL_W-1:0]   k;
    logic [2*LEVEL_W-1:0] ksq;
  } chan_t;

endpackage

@@ hdl/sample_average_gamma_to_rgb8_unit.sv @@
// Channel      | Dir | Signals                         | Payload
// s_axis       | in  | tvalid, tready, tdata[95:0]     | red_sum, green_sum, blue_sum
// m_axis       | out | tvalid, tready, tdata[23:0]     | red_level, green_level, blue_level
// sample_count | in  | sample_count_we_i, _i[15:0]     | samples per sum
//
// One pixel per cycle unless m_axis stalls; one stage scales the sums by 255^2,
// then one stage per result bit of the 8-bit root search (16x16 multiply + compare).
// Reset clears all valid bits; sample_count resets to 1.
// A stall on m_axis freezes the whole pipeline; s_axis_tready drops with it.
module sample_average_gamma_to_rgb8_unit
  import sagr_pkg::*;
#(
  parameter int unsigned SUM_WIDTH = DEFAULT_SUM_WIDTH,
  parameter int unsigned FRAC_BITS = DEFAULT_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  sample_count_we_i,
  input  logic [COUNT_W-1:0]    sample_count_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [3*SUM_FIELD_W-1:0] s_axis_tdata,  // red_sum, green_sum, blue_sum
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [3*LEVEL_W-1:0]  m_axis_tdata    // red_level, green_level, blue_level
);

  localparam int unsigned RHS_W   = SUM_WIDTH + 16;
  localparam int unsigned LHS_W   = 2 * LEVEL_W + COUNT_W + FRAC_BITS;
  localparam int unsigned CMP_W   = (RHS_W > LHS_W) ? RHS_W : LHS_W;
  localparam int unsigned EXT_W   = SUM_WIDTH + SUM_FIELD_W;

  logic [COUNT_W-1:0] count_q;
  logic               en;

  logic [LEVEL_W:0]                        valid_s;
  logic [LEVEL_W:0][NUM_CHAN-1:0][RHS_W-1:0] rhs_s;
  chan_t [LEVEL_W:0][NUM_CHAN-1:0]         chan_s;
  logic [NUM_CHAN-1:0][RHS_W-1:0]          rhs_d;
  logic                                    valid_q;
  logic [NUM_CHAN-1:0][RHS_W-1:0]          rhs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (sample_count_we_i) begin
      count_q <= sample_count_i;
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // sum * 65025 = (s << 16) - (s << 9) + s
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      logic [EXT_W-1:0]     ext;
      logic [SUM_WIDTH-1:0] s;
      ext      = EXT_W'(s_axis_tdata[c*SUM_FIELD_W +: SUM_FIELD_W]);
      s        = ext[SUM_WIDTH-1:0];
      rhs_d[c] = (RHS_W'(s) << 16) - (RHS_W'(s) << 9) + RHS_W'(s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rhs_q <= rhs_d;
    end
  end

  assign valid_s[0] = valid_q;
  assign rhs_s[0]   = rhs_q;
  assign chan_s[0]  = '0;

  for (genvar g = 0; g < LEVEL_W; g++) begin : g_step
    sagr_step #(
      .RHS_W    (RHS_W),
      .CMP_W    (CMP_W),
      .FRAC_BITS(FRAC_BITS),
      .BIT_POS  (LEVEL_W - 1 - g)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(valid_s[g]),
      .count_i(count_q),
      .rhs_i  (rhs_s[g]),
      .chan_i (chan_s[g]),
      .valid_o(valid_s[g+1]),
      .rhs_o  (rhs_s[g+1]),
      .chan_o (chan_s[g+1])
    );
  end

  assign m_axis_tvalid = valid_s[LEVEL_W];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      m_axis_tdata[c*LEVEL_W +: LEVEL_W] = chan_s[LEVEL_W][c].k;
    end
  end

endmodule

@@ hdl/sagr_step.sv @@
// One bit of the root search for all channels, registered.
module sagr_step
  import sagr_pkg::*;
#(
  parameter int unsigned RHS_W     = 48,
  parameter int unsigned CMP_W     = 48,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned BIT_POS   = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [COUNT_W-1:0]                 count_i,
  input  logic [NUM_CHAN-1:0][RHS_W-1:0]     rhs_i,
  input  chan_t [NUM_CHAN-1:0]               chan_i,
  output logic                               valid_o,
  output logic [NUM_CHAN-1:0][RHS_W-1:0]     rhs_o,
  output chan_t [NUM_CHAN-1:0]               chan_o
);

  logic                             valid_q;
  logic [NUM_CHAN-1:0][RHS_W-1:0]   rhs_q;
  chan_t [NUM_CHAN-1:0]             chan_q, chan_d;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      logic [LEVEL_W-1:0]         t;
      logic [2*LEVEL_W-1:0]       tsq;
      logic [2*LEVEL_W+COUNT_W-1:0] prod;
      logic [CMP_W-1:0]           lhs;
      t    = chan_i[c].k | (LEVEL_W'(1) << BIT_POS);
      tsq  = chan_i[c].ksq + ((2*LEVEL_W)'(chan_i[c].k) << (BIT_POS + 1))
             + ((2*LEVEL_W)'(1) << (2 * BIT_POS));
      prod = (2*LEVEL_W+COUNT_W)'(tsq) * (2*LEVEL_W+COUNT_W)'(count_i);
      lhs  = CMP_W'(prod) << FRAC_BITS;
      chan_d[c] = chan_i[c];
      if ((t <= LEVEL_MAX) && (lhs <= CMP_W'(rhs_i[c]))) begin
        chan_d[c].k   = t;
        chan_d[c].ksq = tsq;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rhs_q  <= rhs_i;
      chan_q <= chan_d;
    end
  end

  assign valid_o = valid_q;
  assign rhs_o   = rhs_q;
  assign chan_o  = chan_q;

endmodule
